// ===== src/text_console_cursor_engine_top_macros.svh =====
// Assertion macros for the console cursor engine. Each expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH

// cond must hold at every edge out of reset
`define TCCE_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tcce: invariant violated");

// once trig is seen, cond must hold in the next cycle
`define TCCE_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("tcce: next-cycle check failed");

`endif

// ===== src/tcce_pkg.sv =====
`timescale 1ns / 1ps
package tcce_pkg;

  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int CLR_W = 4;
  localparam int CHR_W = 8;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_BACKGROUND = 2'd0;
  localparam logic [IDX_W-1:0] REG_FG_PRESET  = 2'd1;

  localparam logic [CLR_W-1:0] FG_RESET = 4'd7;

  localparam logic [CHR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHR_W-1:0] CH_ESC = 8'h26;

  typedef logic [2:0] op_t;
  localparam op_t OP_NOP   = 3'd0;
  localparam op_t OP_CELL  = 3'd1;
  localparam op_t OP_LF    = 3'd2;
  localparam op_t OP_TAB   = 3'd3;
  localparam op_t OP_CR    = 3'd4;
  localparam op_t OP_ESC   = 3'd5;
  localparam op_t OP_COLOR = 3'd6;

  typedef struct packed {
    op_t              op;
    logic [CHR_W-1:0] glyph;
    logic [CLR_W-1:0] color;
    logic             show_cursor;
  } entry_t;

  typedef struct packed {
    logic             cell_write;
    logic [COL_W-1:0] cell_column;
    logic [ROW_W-1:0] cell_row;
    logic [CHR_W-1:0] cell_glyph;
    logic [CLR_W-1:0] cell_foreground;
    logic [CLR_W-1:0] cell_background;
    logic             serial_valid;
    logic [CHR_W-1:0] serial_byte;
    logic             scroll_up;
    logic             cursor_update;
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
  } result_t;

  function automatic logic [CLR_W-1:0] hex_value(input logic [CHR_W-1:0] ch);
    logic [CHR_W-1:0] d;
    begin
      d = '0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
        d = ch - 8'h30;
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
        d = ch - 8'h57;
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
        d = ch - 8'h37;
      end
      return d[CLR_W-1:0];
    end
  endfunction

endpackage

// ===== src/tcce_front.sv =====
`timescale 1ns / 1ps
module tcce_front import tcce_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             action,
  input  logic [CHR_W-1:0] character,
  input  logic             last_of_message,
  output entry_t           entry
);

  logic esc_r;
  logic esc_nxt;

  // classify the character against the pending escape
  always_comb begin
    entry.glyph       = character;
    entry.color       = '0;
    entry.show_cursor = last_of_message;
    entry.op          = OP_NOP;
    esc_nxt           = esc_r;
    if (action) begin
      entry.op          = OP_CELL;
      entry.show_cursor = 1'b1;
    end else begin
      if (character != CH_NUL) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (character == CH_ESC) begin
            entry.op = OP_CELL;
          end else begin
            entry.op    = OP_COLOR;
            entry.color = hex_value(character);
          end
        end else if (character == CH_ESC) begin
          entry.op = OP_ESC;
          esc_nxt  = 1'b1;
        end else begin
          priority if (character == CH_LF) begin
            entry.op = OP_LF;
          end else if (character == CH_TAB) begin
            entry.op = OP_TAB;
          end else if (character == CH_CR) begin
            entry.op = OP_CR;
          end else begin
            entry.op = OP_CELL;
          end
        end
      end
      // drop the escape at message end
      if (last_of_message) begin
        esc_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else if (push) begin
      esc_r <= esc_nxt;
    end
  end

endmodule

// ===== src/tcce_queue.sv =====
`timescale 1ns / 1ps
module tcce_queue import tcce_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t pop_entry
);

  entry_t     slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/tcce_back.sv =====
`timescale 1ns / 1ps
module tcce_back import tcce_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CLR_W-1:0] cfg_wdata,
  input  logic             q_not_empty,
  input  entry_t           q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          result
);

  localparam int PH_W = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;
  localparam logic [COL_W:0]   COLS_X  = (COL_W+1)'(SCREEN_COLUMNS);
  localparam logic [ROW_W:0]   ROWS_X  = (ROW_W+1)'(SCREEN_ROWS);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W:0]   TAB_X   = (COL_W+1)'(TAB_STOP);
  localparam logic [PH_W-1:0]  PH_MAX  = PH_W'(TAB_STOP - 1);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [CLR_W-1:0] fg_r, fg_nxt;
  logic [CLR_W-1:0] bg_r;
  logic             out_valid_r;
  result_t          result_r, result_nxt;

  logic [COL_W:0]   c_step;
  logic [ROW_W-1:0] r_step;
  logic [ROW_W-1:0] r_wrap;
  logic             do_cell;
  logic             do_echo;
  logic             scroll;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign result    = result_r;

  // cursor move for this entry, before wrap and scroll
  always_comb begin
    c_step  = {1'b0, col_r};
    r_step  = row_r;
    fg_nxt  = fg_r;
    do_cell = 1'b0;
    do_echo = 1'b0;
    unique case (q_entry.op)
      OP_CELL: begin
        c_step  = {1'b0, col_r} + 1'b1;
        do_cell = 1'b1;
        do_echo = 1'b1;
      end
      OP_LF: begin
        c_step  = '0;
        r_step  = row_r + 1'b1;
        do_echo = 1'b1;
      end
      OP_TAB: begin
        c_step  = {1'b0, col_r} + TAB_X - (COL_W+1)'(phase_r);
        do_echo = 1'b1;
      end
      OP_CR: begin
        c_step  = '0;
        do_echo = 1'b1;
      end
      OP_COLOR: begin
        fg_nxt = q_entry.color;
      end
      default: begin
      end
    endcase
  end

  // wrap at the row end, then scroll at the bottom
  always_comb begin
    col_nxt = c_step[COL_W-1:0];
    r_wrap  = r_step;
    scroll  = 1'b0;
    if (c_step >= COLS_X) begin
      col_nxt = '0;
      r_wrap  = r_step + 1'b1;
    end
    row_nxt = r_wrap;
    if ({1'b0, r_wrap} >= ROWS_X) begin
      col_nxt = '0;
      row_nxt = ROW_MAX;
      scroll  = 1'b1;
    end
    // a tab always lands on a stop, so its phase restarts as well
    if (col_nxt == '0 || q_entry.op == OP_TAB) begin
      phase_nxt = '0;
    end else if (q_entry.op == OP_CELL) begin
      phase_nxt = (phase_r == PH_MAX) ? '0 : phase_r + 1'b1;
    end else begin
      phase_nxt = phase_r;
    end
  end

  always_comb begin
    result_nxt                 = '0;
    result_nxt.scroll_up       = scroll;
    if (do_cell) begin
      result_nxt.cell_write      = 1'b1;
      result_nxt.cell_column     = col_r;
      result_nxt.cell_row        = row_r;
      result_nxt.cell_glyph      = q_entry.glyph;
      result_nxt.cell_foreground = fg_r;
      result_nxt.cell_background = bg_r;
    end
    if (do_echo) begin
      result_nxt.serial_valid = 1'b1;
      result_nxt.serial_byte  = q_entry.glyph;
    end
    if (q_entry.show_cursor) begin
      result_nxt.cursor_update = 1'b1;
      result_nxt.cursor_column = col_nxt;
      result_nxt.cursor_row    = row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= '0;
      fg_r        <= FG_RESET;
      bg_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        phase_r     <= phase_nxt;
        fg_r        <= fg_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && cfg_index == REG_BACKGROUND) begin
        bg_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_FG_PRESET) begin
        fg_r <= cfg_wdata;
      end
    end
  end

`include "text_console_cursor_engine_top_macros.svh"

  `TCCE_ASSERT_ALWAYS(a_cursor_on_screen,
    ({1'b0, col_r} < COLS_X) && ({1'b0, row_r} < ROWS_X))
  `TCCE_ASSERT_ALWAYS(a_cell_echoed,
    !(out_valid_r && result_r.cell_write) ||
    (result_r.serial_valid && result_r.serial_byte == result_r.cell_glyph))
  `TCCE_ASSERT_NEXT(a_scroll_home, q_pop && scroll,
    col_r == '0 && row_r == ROW_MAX && phase_r == '0)

endmodule

// ===== src/text_console_cursor_engine_top.sv =====
`timescale 1ns / 1ps
// Text console cursor engine: turns a stream of character requests into
// screen cell writes, serial echo bytes, scroll requests and cursor moves.
// Input channel (in_*): one character per request, with in_action picking
//   interpreted (0) or raw (1) handling and in_last_of_message closing an
//   interpreted message. Every request yields exactly one result.
// Result channel (out_*): one result per request, in request order.
// Configuration (cfg_*): index 0 sets the background, index 1 loads the
//   foreground; write only while no request is in flight.
// A request is written into the queue, then its result into the output register.
// Throughput: one request per cycle while the receiver takes results; a
//   two-entry queue sits between classifier and back end.
// When the receiver stalls, the output register holds its result, the queue
//   fills, and in_ready drops once both queue entries are taken.
// Reset: cursor at column 0, row 0, foreground 7, background 0, no escape
//   pending, queue and output empty.
module text_console_cursor_engine_top import tcce_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CLR_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [CHR_W-1:0] in_character,
  input  logic             in_last_of_message,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_cell_write,
  output logic [COL_W-1:0] out_cell_column,
  output logic [ROW_W-1:0] out_cell_row,
  output logic [CHR_W-1:0] out_cell_glyph,
  output logic [CLR_W-1:0] out_cell_foreground,
  output logic [CLR_W-1:0] out_cell_background,
  output logic             out_serial_valid,
  output logic [CHR_W-1:0] out_serial_byte,
  output logic             out_scroll_up,
  output logic             out_cursor_update,
  output logic [COL_W-1:0] out_cursor_column,
  output logic [ROW_W-1:0] out_cursor_row
);

  logic    q_full;
  logic    q_not_empty;
  logic    q_pop;
  logic    push;
  entry_t  push_entry;
  entry_t  pop_entry;
  result_t res;

  // accept whenever the queue has room; never looks at out_ready
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // classify the character and track the pending escape
  tcce_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .action          (in_action),
    .character       (in_character),
    .last_of_message (in_last_of_message),
    .entry           (push_entry)
  );

  // decouple the classifier from the cursor back end
  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  // advance the cursor, build the result and hold it until taken
  tcce_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .TAB_STOP       (TAB_STOP)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_entry     (pop_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (res)
  );

  assign out_cell_write      = res.cell_write;
  assign out_cell_column     = res.cell_column;
  assign out_cell_row        = res.cell_row;
  assign out_cell_glyph      = res.cell_glyph;
  assign out_cell_foreground = res.cell_foreground;
  assign out_cell_background = res.cell_background;
  assign out_serial_valid    = res.serial_valid;
  assign out_serial_byte     = res.serial_byte;
  assign out_scroll_up       = res.scroll_up;
  assign out_cursor_update   = res.cursor_update;
  assign out_cursor_column   = res.cursor_column;
  assign out_cursor_row      = res.cursor_row;

endmodule

// ===== test/tb_text_console_cursor_engine_top.sv =====
`timescale 1ns / 1ps
module tb_text_console_cursor_engine_top;
  import tcce_pkg::*;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_STOP       = 8;

  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(SCREEN_COLUMNS);
  localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(SCREEN_ROWS);
  localparam logic [COL_W-1:0] TAB_STEP  = COL_W'(TAB_STOP);

  // Indexes past the last register; writes there must change nothing.
  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Cycles without any request or result moving before the run is declared hung.
  // The slowest correct stretch is a sender gap, a receiver stall and the
  // pipeline through queue and output register, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic             action;
    logic [CHR_W-1:0] character;
    logic             last;
  } char_req_t;

  logic             clk                = 1'b0;
  logic             rst_n              = 1'b0;
  logic             cfg_we             = 1'b0;
  logic [IDX_W-1:0] cfg_index          = '0;
  logic [CLR_W-1:0] cfg_wdata          = '0;
  logic             in_valid           = 1'b0;
  logic             in_ready;
  logic             in_action          = 1'b0;
  logic [CHR_W-1:0] in_character       = '0;
  logic             in_last_of_message = 1'b0;
  logic             out_valid;
  logic             out_ready          = 1'b0;
  logic             out_cell_write;
  logic [COL_W-1:0] out_cell_column;
  logic [ROW_W-1:0] out_cell_row;
  logic [CHR_W-1:0] out_cell_glyph;
  logic [CLR_W-1:0] out_cell_foreground;
  logic [CLR_W-1:0] out_cell_background;
  logic             out_serial_valid;
  logic [CHR_W-1:0] out_serial_byte;
  logic             out_scroll_up;
  logic             out_cursor_update;
  logic [COL_W-1:0] out_cursor_column;
  logic [ROW_W-1:0] out_cursor_row;

  text_console_cursor_engine_top #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS),
    .TAB_STOP      (TAB_STOP)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_character       (in_character),
    .in_last_of_message (in_last_of_message),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cell_write     (out_cell_write),
    .out_cell_column    (out_cell_column),
    .out_cell_row       (out_cell_row),
    .out_cell_glyph     (out_cell_glyph),
    .out_cell_foreground(out_cell_foreground),
    .out_cell_background(out_cell_background),
    .out_serial_valid   (out_serial_valid),
    .out_serial_byte    (out_serial_byte),
    .out_scroll_up      (out_scroll_up),
    .out_cursor_update  (out_cursor_update),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Requests waiting to be driven, and the console results they must produce.
  char_req_t char_backlog[$];
  result_t   results_due[$];
  int        fail_count  = 0;
  int        quiet_cycles = 0;

  // Shadow console state, updated as each request is accepted or a register written.
  logic [COL_W-1:0] pos_col     = '0;
  logic [ROW_W-1:0] pos_row     = '0;
  logic [CLR_W-1:0] fg_now      = FG_RESET;
  logic [CLR_W-1:0] bg_now      = '0;
  logic             escape_open = 1'b0;

  // Idle pacing per side: a stretch either idles at random or runs flat out.
  int        send_wait    = 0;
  int        send_stretch = 0;
  bit        send_idling  = 1'b0;
  int        take_wait    = 0;
  int        take_stretch = 0;
  bit        take_idling  = 1'b0;
  char_req_t next_req;
  result_t   due;

  function automatic int draw_wait(inout int stretch, inout bit idling);
    if (stretch == 0) begin
      stretch = $urandom_range(16, 64);
      idling  = ($urandom_range(0, 2) != 0);
    end
    stretch--;
    return idling ? int'($urandom_range(0, 3)) : 0;
  endfunction

  // Advance the shadow console by one character and return what the block
  // must report for it.
  function automatic result_t render_char(input logic raw, input logic [CHR_W-1:0] ch,
                                          input logic last);
    result_t          r;
    logic             put_cell;
    logic             echo;
    logic             show;
    logic [COL_W-1:0] col0;
    logic [ROW_W-1:0] row0;
    logic [CHR_W-1:0] digit;
    r        = '0;
    put_cell = 1'b0;
    echo     = 1'b0;
    show     = 1'b0;
    col0     = pos_col;
    row0     = pos_row;
    digit    = '0;
    if (raw) begin
      // Raw puts bypass the escape logic and always move the cursor.
      put_cell = 1'b1;
      echo     = 1'b1;
      show     = 1'b1;
      pos_col  = pos_col + 1'b1;
    end else if (ch != CH_NUL) begin
      if (escape_open) begin
        escape_open = 1'b0;
        if (ch == CH_ESC) begin
          put_cell = 1'b1;
          echo     = 1'b1;
          pos_col  = pos_col + 1'b1;
        end else begin
          // Non-hex selectors fall through to color 0.
          if (ch >= "0" && ch <= "9") begin
            digit = ch - "0";
          end else if (ch >= "a" && ch <= "f") begin
            digit = ch - "a" + 8'd10;
          end else if (ch >= "A" && ch <= "F") begin
            digit = ch - "A" + 8'd10;
          end
          fg_now = digit[CLR_W-1:0];
        end
      end else if (ch == CH_ESC) begin
        escape_open = 1'b1;
      end else begin
        case (ch)
          CH_LF: begin
            pos_row = pos_row + 1'b1;
            pos_col = '0;
          end
          CH_TAB: begin
            pos_col = pos_col + TAB_STEP - (pos_col % TAB_STEP);
          end
          CH_CR: begin
            pos_col = '0;
          end
          default: begin
            put_cell = 1'b1;
            pos_col  = pos_col + 1'b1;
          end
        endcase
        echo = 1'b1;
      end
    end
    // Wrap at the right edge, then scroll once the cursor falls off the bottom.
    if (raw || ch != CH_NUL) begin
      if (pos_col >= COL_LIMIT) begin
        pos_col = '0;
        pos_row = pos_row + 1'b1;
      end
      if (pos_row >= ROW_LIMIT) begin
        pos_col     = '0;
        pos_row     = ROW_LIMIT - 1'b1;
        r.scroll_up = 1'b1;
      end
    end
    if (!raw && last) begin
      escape_open = 1'b0;
      show        = 1'b1;
    end
    if (put_cell) begin
      r.cell_write      = 1'b1;
      r.cell_column     = col0;
      r.cell_row        = row0;
      r.cell_glyph      = ch;
      r.cell_foreground = fg_now;
      r.cell_background = bg_now;
    end
    if (echo) begin
      r.serial_valid = 1'b1;
      r.serial_byte  = ch;
    end
    if (show) begin
      r.cursor_update = 1'b1;
      r.cursor_column = pos_col;
      r.cursor_row    = pos_row;
    end
    return r;
  endfunction

  // Driver: track register writes and accepted requests in the shadow state,
  // then hold the current request or present the next one after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BACKGROUND) begin
          bg_now = cfg_wdata;
        end else if (cfg_index == REG_FG_PRESET) begin
          fg_now = cfg_wdata;
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(render_char(in_action, in_character, in_last_of_message));
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (char_backlog.size() != 0) begin
          next_req           = char_backlog.pop_front();
          in_valid           <= 1'b1;
          in_action          <= next_req.action;
          in_character       <= next_req.character;
          in_last_of_message <= next_req.last;
          send_wait          = draw_wait(send_stretch, send_idling);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: match each accepted result against the oldest expectation,
  // then stall the result channel for a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          due = results_due.pop_front();
          check_field("cell_write", 8'(due.cell_write), 8'(out_cell_write));
          check_field("cell_column", 8'(due.cell_column), 8'(out_cell_column));
          check_field("cell_row", 8'(due.cell_row), 8'(out_cell_row));
          check_field("cell_glyph", due.cell_glyph, out_cell_glyph);
          check_field("cell_foreground", 8'(due.cell_foreground),
                      8'(out_cell_foreground));
          check_field("cell_background", 8'(due.cell_background),
                      8'(out_cell_background));
          check_field("serial_valid", 8'(due.serial_valid), 8'(out_serial_valid));
          check_field("serial_byte", due.serial_byte, out_serial_byte);
          check_field("scroll_up", 8'(due.scroll_up), 8'(out_scroll_up));
          check_field("cursor_update", 8'(due.cursor_update), 8'(out_cursor_update));
          check_field("cursor_column", 8'(due.cursor_column), 8'(out_cursor_column));
          check_field("cursor_row", 8'(due.cursor_row), 8'(out_cursor_row));
        end
        take_wait = draw_wait(take_stretch, take_idling);
      end
      if (take_wait > 0) begin
        out_ready <= 1'b0;
        take_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_char(input logic raw, input logic [CHR_W-1:0] ch, input logic last);
    char_backlog.push_back('{action: raw, character: ch, last: last});
  endtask

  // Message body byte: mostly printable, with control codes and stray bytes
  // mixed in. Line mode keeps to text and tabs so the row fills and wraps.
  function automatic logic [CHR_W-1:0] text_char(input bit line);
    int pick;
    pick = $urandom_range(0, 99);
    if (line) begin
      return (pick < 15) ? CH_TAB : CHR_W'($urandom_range(32, 126));
    end
    if (pick < 55) return CHR_W'($urandom_range(32, 126));
    if (pick < 65) return CH_LF;
    if (pick < 71) return CH_CR;
    if (pick < 80) return CH_TAB;
    if (pick < 83) return CH_NUL;
    return CHR_W'($urandom_range(0, 255));
  endfunction

  // Byte after an escape: usually a hex digit of either case, sometimes a
  // second escape or anything at all.
  function automatic logic [CHR_W-1:0] escape_arg();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(0, 21);
    if (pick >= 85) return CHR_W'($urandom_range(0, 255));
    if (pick >= 70) return CH_ESC;
    if (n < 10) return CHR_W'("0" + n);
    if (n < 16) return CHR_W'("a" + n - 10);
    return CHR_W'("A" + n - 16);
  endfunction

  task automatic queue_message(input int len, input bit line);
    bit last;
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      if (!line && $urandom_range(0, 9) == 0) begin
        add_char(1'b0, CH_ESC, 1'b0);
        add_char(1'b0, escape_arg(), last);
      end else begin
        add_char(1'b0, text_char(line), last);
      end
    end
  endtask

  // Malformed traffic: dangling escapes, raw puts inside an escape, NUL
  // closing a message, and text that never closes its message.
  task automatic queue_broken();
    case ($urandom_range(0, 3))
      0: begin
        repeat ($urandom_range(0, 4)) add_char(1'b0, text_char(1'b0), 1'b0);
        add_char(1'b0, CH_ESC, 1'b1);
        add_char(1'b0, escape_arg(), 1'($urandom_range(0, 1)));
      end
      1: begin
        add_char(1'b0, CH_ESC, 1'b0);
        add_char(1'b1, CHR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        add_char(1'b0, escape_arg(), 1'b1);
      end
      2: begin
        add_char(1'b0, CH_ESC, 1'b0);
        add_char(1'b0, CH_NUL, 1'($urandom_range(0, 1)));
        add_char(1'b0, escape_arg(), 1'b1);
      end
      default: begin
        repeat ($urandom_range(1, 6)) add_char(1'b0, text_char(1'b0), 1'b0);
      end
    endcase
  endtask

  task automatic queue_random(input int count);
    int goal;
    int kind;
    goal = char_backlog.size() + count;
    while (char_backlog.size() < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        queue_message($urandom_range(1, 16), 1'b0);
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 12)) begin
          add_char(1'b1, CHR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end else if (kind < 76) begin
        queue_message($urandom_range(30, 90), 1'b1);
      end else if (kind < 90) begin
        queue_broken();
      end else begin
        add_char(1'($urandom_range(0, 1)), CHR_W'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Directed opening, run with the reset colors: plain text, every escape
  // form, the control codes, NUL ending an escape, raw puts, raw inside an
  // escape, and the byte extremes in both modes.
  task automatic queue_directed();
    add_char(1'b0, "A", 1'b0);
    add_char(1'b0, CH_ESC, 1'b0);
    add_char(1'b0, "3", 1'b0);
    add_char(1'b0, "B", 1'b0);
    add_char(1'b0, CH_ESC, 1'b0);
    add_char(1'b0, CH_ESC, 1'b0);
    add_char(1'b0, CH_ESC, 1'b0);
    add_char(1'b0, "z", 1'b0);
    add_char(1'b0, "C", 1'b0);
    add_char(1'b0, CH_ESC, 1'b0);
    add_char(1'b0, "F", 1'b0);
    add_char(1'b0, CH_ESC, 1'b0);
    add_char(1'b0, "a", 1'b0);
    add_char(1'b0, CH_TAB, 1'b0);
    add_char(1'b0, CH_CR, 1'b0);
    add_char(1'b0, CH_LF, 1'b1);
    add_char(1'b0, CH_ESC, 1'b0);
    add_char(1'b0, CH_NUL, 1'b1);
    add_char(1'b0, "5", 1'b1);
    add_char(1'b0, CH_ESC, 1'b0);
    add_char(1'b1, "Q", 1'b0);
    add_char(1'b0, "2", 1'b1);
    add_char(1'b1, 8'hFF, 1'b0);
    add_char(1'b1, 8'h00, 1'b1);
    add_char(1'b0, 8'hFF, 1'b1);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CLR_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // Write both color registers in random order, optionally poke the unused
  // indexes, then drop the write enable.
  task automatic load_colors(input logic [CLR_W-1:0] bg, input logic [CLR_W-1:0] fg,
                             input bit stray);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_BACKGROUND, bg);
      write_reg(REG_FG_PRESET, fg);
    end else begin
      write_reg(REG_FG_PRESET, fg);
      write_reg(REG_BACKGROUND, bg);
    end
    if (stray) begin
      write_reg(REG_SPARE_A, CLR_W'($urandom_range(0, 15)));
      write_reg(REG_SPARE_B, CLR_W'($urandom_range(0, 15)));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    #1;
  endtask

  // Hold until every request is out and every result is back, then let the
  // pipeline settle. Sample after the edge so all updates settled.
  task automatic wait_idle();
    while (char_backlog.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
    #1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;
    queue_directed();
    queue_random(150);
    wait_idle();
    // Walk the color extremes, then random settings.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_colors(4'd15, 4'd15, 1'b0);
        1: load_colors(4'd0, 4'd0, 1'b1);
        2: load_colors(4'd15, 4'd0, 1'b0);
        3: load_colors(4'd0, 4'd15, 1'b1);
        default: begin
          load_colors(CLR_W'($urandom_range(0, 15)), CLR_W'($urandom_range(0, 15)), 1'b1);
        end
      endcase
      queue_random(190);
      wait_idle();
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
